FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the dequantizing dot-product RTL.
// Each macro expects clk_i and rst_ni to be in scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/q4dq_pkg.sv
// Package for the 4-bit dequantizing dot product: widths, beat types, control structs.
// Has no dependencies; used by every module of the block.
`default_nettype none

package q4dq_pkg;

  localparam int unsigned NIB_W   = 4;
  localparam int unsigned NLANES  = 2;
  localparam int unsigned DATA_W  = 16;
  // Nibble times scale plus zero fits 20 signed bits exactly.
  localparam int unsigned DQ_W    = 20;
  localparam int unsigned PROD_W  = DQ_W + DATA_W;
  localparam int unsigned PAIR_W  = PROD_W + 1;
  localparam int unsigned ACC_W   = 48;

  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic [7:0]               weight_byte;
    logic signed [DATA_W-1:0] act_even;
    logic signed [DATA_W-1:0] act_odd;
    logic signed [DATA_W-1:0] block_scale;
    logic signed [DATA_W-1:0] block_zero;
    logic                     last;
  } in_beat_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] dot_sum;
    logic                    saturated;
  } out_beat_t;

  // Pipeline control that travels into the merging stage.
  typedef struct packed {
    logic adv;
    logic vld;
    logic last;
  } pipe_ctl_t;

  // Status reported back by the merging stage.
  typedef struct packed {
    logic acc_zero;
    logic pair_vld;
  } merge_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/q4dq_lane.sv
// One lane: dequantizes a signed nibble and multiplies it by its activation.
// Depends on q4dq_pkg.
`default_nettype none

module q4dq_lane (
  input  logic                                  clk_i,
  input  logic                                  adv_i,
  input  logic [q4dq_pkg::NIB_W-1:0]            nibble_i,
  input  logic signed [q4dq_pkg::DATA_W-1:0]    scale_i,
  input  logic signed [q4dq_pkg::DATA_W-1:0]    zero_i,
  input  logic signed [q4dq_pkg::DATA_W-1:0]    act_i,
  output q4dq_pkg::prod_t                       prod_o
);

  logic signed [q4dq_pkg::DQ_W-1:0]   nib_x;
  logic signed [q4dq_pkg::DQ_W-1:0]   scale_x;
  logic signed [q4dq_pkg::DQ_W-1:0]   zero_x;
  logic signed [q4dq_pkg::DQ_W-1:0]   dq_d, dq_q;
  logic signed [q4dq_pkg::DATA_W-1:0] act_q;
  logic signed [q4dq_pkg::PROD_W-1:0] dq_px, act_px;
  q4dq_pkg::prod_t                    prod_d, prod_q;

  // Stage one: sign-extend the nibble and apply scale and offset.
  always_comb begin
    nib_x   = q4dq_pkg::DQ_W'($signed(nibble_i));
    scale_x = q4dq_pkg::DQ_W'(scale_i);
    zero_x  = q4dq_pkg::DQ_W'(zero_i);
    dq_d    = nib_x * scale_x + zero_x;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dq_q  <= dq_d;
      act_q <= act_i;
    end
  end

  // Stage two: multiply the dequantized weight by its activation.
  always_comb begin
    dq_px  = q4dq_pkg::PROD_W'(dq_q);
    act_px = q4dq_pkg::PROD_W'(act_q);
    prod_d = dq_px * act_px;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: rtl/core/q4dq_merge.sv
// Merging stage: sums the lane products, accumulates with saturation, holds the result.
// Depends on q4dq_pkg.
`default_nettype none

module q4dq_merge (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  q4dq_pkg::pipe_ctl_t     ctl_i,
  input  q4dq_pkg::prod_t         prod_i [q4dq_pkg::NLANES],
  output q4dq_pkg::merge_sts_t    sts_o,
  output logic                    out_valid_o,
  output q4dq_pkg::out_beat_t     out_data_o
);

  localparam int unsigned SUM_W = q4dq_pkg::ACC_W + 1;

  logic signed [q4dq_pkg::PAIR_W-1:0] pair_d, pair_q;
  logic                               pair_vld_q, pair_last_q;
  logic signed [q4dq_pkg::ACC_W-1:0]  acc_d, acc_q;
  logic                               clip_d, clip_q;
  logic signed [SUM_W-1:0]            sum;
  logic                               ovf;
  logic signed [q4dq_pkg::ACC_W-1:0]  sat_sum;
  logic                               out_valid_d, out_valid_q;
  q4dq_pkg::out_beat_t                out_d, out_q;

  // Exact sum of the lane products.
  always_comb begin
    pair_d = '0;
    for (int i = 0; i < q4dq_pkg::NLANES; i++) begin
      pair_d = pair_d + q4dq_pkg::PAIR_W'(prod_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      pair_q <= pair_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_vld_q  <= 1'b0;
      pair_last_q <= 1'b0;
    end else if (ctl_i.adv) begin
      pair_vld_q  <= ctl_i.vld;
      pair_last_q <= ctl_i.last;
    end
  end

  // Saturating accumulate; overflow shows as the top two sum bits disagreeing.
  always_comb begin
    sum     = SUM_W'(acc_q) + SUM_W'(pair_q);
    ovf     = sum[SUM_W-1] != sum[SUM_W-2];
    sat_sum = sum[SUM_W-2:0];
    if (ovf) begin
      sat_sum = sum[SUM_W-1] ? {1'b1, {(q4dq_pkg::ACC_W-1){1'b0}}}
                             : {1'b0, {(q4dq_pkg::ACC_W-1){1'b1}}};
    end
  end

  // Next accumulator, clip flag and output beat.
  always_comb begin
    acc_d       = acc_q;
    clip_d      = clip_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (ctl_i.adv) begin
      out_valid_d = 1'b0;
      if (pair_vld_q) begin
        if (pair_last_q) begin
          out_valid_d       = 1'b1;
          out_d.dot_sum     = sat_sum;
          out_d.saturated   = clip_q | ovf;
          acc_d             = '0;
          clip_d            = 1'b0;
        end else begin
          acc_d  = sat_sum;
          clip_d = clip_q | ovf;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      clip_q      <= clip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;
  assign sts_o.acc_zero = (acc_q == '0) && !clip_q;
  assign sts_o.pair_vld = pair_vld_q;

endmodule

`default_nettype wire

FILE: rtl/core/q4dq_dot_top_placeholder.sv
// Small valid/last delay line for the lane stages of the dot product.
// Depends on q4dq_pkg.
`default_nettype none

module q4dq_ctl_pipe (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 vld_i,
  input  logic                 last_i,
  output q4dq_pkg::pipe_ctl_t  ctl_o
);

  logic s1_vld_q, s1_last_q, s2_vld_q, s2_last_q;

  // Valid and last follow the two lane register stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q  <= vld_i;
      s1_last_q <= last_i;
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;
    end
  end

  assign ctl_o.adv  = adv_i;
  assign ctl_o.vld  = s2_vld_q;
  assign ctl_o.last = s2_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/q4_dequant_dot_product.sv
// Top level of the 4-bit dequantizing dot product: two nibble lanes and a merging stage.
// Depends on q4dq_pkg, q4dq_lane, q4dq_ctl_pipe, q4dq_merge and assert_macros.svh.
//
// Usage:
//   While in_stall_o is low, the input channel (in_valid_i, in_stall_o, in_data_i)
//   takes one beat per cycle: a packed weight byte, the two matching activations,
//   the block scale and zero, and a last marker. The low nibble goes to lane 0,
//   the high nibble to lane 1. Every beat is folded into a 48-bit saturating
//   accumulator; the beat marked last produces one output beat
//   (out_valid_o/out_stall_i, out_data_o) holding the sum and a sticky clip flag,
//   after which the accumulator is cleared. Throughput is one beat per cycle
//   while the output is not stalled. The result of a last beat passes through
//   two lane stages (dequantize, multiply), a pair-sum register, and the
//   accumulate stage that loads the output register.
//   When the output beat is stalled, the whole pipeline holds and in_stall_o is
//   raised until the beat is taken.
//   Reset clears the accumulator, the clip flag and all valid bits.
`default_nettype none

module q4_dequant_dot_product (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  q4dq_pkg::in_beat_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output q4dq_pkg::out_beat_t   out_data_o
);

  `include "assert_macros.svh"

  logic                           adv;
  logic signed [q4dq_pkg::DATA_W-1:0] act [q4dq_pkg::NLANES];
  q4dq_pkg::prod_t                prod [q4dq_pkg::NLANES];
  q4dq_pkg::pipe_ctl_t            ctl;
  q4dq_pkg::merge_sts_t           sts;

  // The pipeline moves unless a finished beat waits on a stalled receiver.
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  assign act[0] = in_data_i.act_even;
  assign act[1] = in_data_i.act_odd;

  // One lane per nibble of the weight byte.
  for (genvar g = 0; g < q4dq_pkg::NLANES; g++) begin : g_lane
    q4dq_lane u_lane (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .nibble_i (in_data_i.weight_byte[g*q4dq_pkg::NIB_W +: q4dq_pkg::NIB_W]),
      .scale_i  (in_data_i.block_scale),
      .zero_i   (in_data_i.block_zero),
      .act_i    (act[g]),
      .prod_o   (prod[g])
    );
  end

  q4dq_ctl_pipe u_ctl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (in_valid_i),
    .last_i (in_data_i.last),
    .ctl_o  (ctl)
  );

  q4dq_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .prod_i      (prod),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // Back-pressure only comes from a held output beat.
  `ASSERT_IMPLIES(a_stall_src, in_stall_o, out_valid_o && out_stall_i)
  // A freshly shown result means the accumulator was just cleared.
  `ASSERT_IMPLIES(a_acc_clear, $rose(out_valid_o), sts.acc_zero)
  // A held output beat freezes the pair stage.
  `ASSERT_NEXT(a_freeze, out_valid_o && out_stall_i, $stable(sts.pair_vld))

endmodule

`default_nettype wire
